FILE: rtl/qdac_pkg.sv
// Package for the quad DAC command register file: payload structs, command codes,
// CSR indexes, and the controller/datapath handshake structs.
// No dependencies.
package qdac_pkg;

   localparam int DATA_W       = 16;  // data_word and read_data width
   localparam int ADDR_W       = 2;   // device address width
   localparam int OP_W         = 4;   // operation code width
   localparam int MASK_W       = 4;   // channel_mask width
   localparam int RSP_CH_W     = 2;   // read_channel width
   localparam int PWR_W        = 2;   // power mode width
   localparam int CSR_IDX_W    = 1;   // configuration register index width
   localparam int CHANNELS_DEF = 4;
   localparam int CODE_BITS_DEF = 16;

   typedef enum logic [OP_W-1:0] {
      OP_NOP          = 4'd0,
      OP_WRITE        = 4'd1,
      OP_UPDATE       = 4'd2,
      OP_WRITE_UPDATE = 4'd3,
      OP_POWER        = 4'd4,
      OP_LDAC_MASK    = 4'd5,
      OP_RESET        = 4'd6,
      OP_LDAC_PULSE   = 4'd7,
      OP_READ_INPUT   = 4'd8,
      OP_READ_DAC     = 4'd9
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_CODE     = 1'd1;

   typedef struct packed {
      logic [ADDR_W-1:0] target_address;
      logic [OP_W-1:0]   operation;
      logic [MASK_W-1:0] channel_mask;
      logic [DATA_W-1:0] data_word;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [RSP_CH_W-1:0] read_channel;
      logic [PWR_W-1:0]    power_mode;
      logic                last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_cmd;   // capture the transferred request
      logic apply;      // execute the captured non-readback command
      logic clear_idx;  // restart the channel scan
      logic step_idx;   // advance the channel scan
      logic load_rsp;   // load the result register from the current channel
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic addr_match; // captured command targets this device
      logic is_read;    // captured command is a readback
      logic sel_bit;    // current scan channel is selected
      logic last_bit;   // no selected channel follows the current one
      logic idx_at_end; // scan sits on the final channel
      logic rsp_free;   // result register can take a new item this cycle
   } stat_type;

endpackage

FILE: rtl/qdac_datapath.sv
// Datapath of the quad DAC command register file: command register, channel
// register file, CSRs, scan counter and result register. Uses qdac_pkg.
module qdac_datapath #(
   parameter int CHANNELS  = qdac_pkg::CHANNELS_DEF,
   parameter int CODE_BITS = qdac_pkg::CODE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qdac_pkg::req_type                  req_payload,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output qdac_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_we,
   input  logic [qdac_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qdac_pkg::DATA_W-1:0]        csr_wdata,
   input  qdac_pkg::ctrl_type                 ctrl,
   output qdac_pkg::stat_type                 stat
);

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PAD_W  = qdac_pkg::DATA_W - CODE_BITS;
   localparam int SEL_W  = (CHANNELS < qdac_pkg::MASK_W) ? CHANNELS : qdac_pkg::MASK_W;
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CHANNELS - 1);

   // Command register
   qdac_pkg::req_type cmd_ff, cmd_in;

   // CSRs
   logic [qdac_pkg::ADDR_W-1:0] dev_addr_ff, dev_addr_in;
   logic [qdac_pkg::DATA_W-1:0] reset_code_ff, reset_code_in;

   // Register file, codes kept as their CODE_BITS significant bits
   logic [CODE_BITS-1:0]          input_reg_ff [CHANNELS];
   logic [CODE_BITS-1:0]          input_reg_in [CHANNELS];
   logic [CODE_BITS-1:0]          dac_reg_ff   [CHANNELS];
   logic [CODE_BITS-1:0]          dac_reg_in   [CHANNELS];
   logic [qdac_pkg::PWR_W-1:0]    power_ff     [CHANNELS];
   logic [qdac_pkg::PWR_W-1:0]    power_in     [CHANNELS];
   logic [CHANNELS-1:0]           ldac_mask_ff, ldac_mask_in;

   // Scan counter and result register
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   qdac_pkg::rsp_type rsp_ff, rsp_in;

   logic [CHANNELS-1:0]  sel;
   logic [CODE_BITS-1:0] code;
   logic [CODE_BITS-1:0] rst_code;
   logic                 last_bit;
   qdac_pkg::op_type     op;

   assign op       = qdac_pkg::op_type'(cmd_ff.operation);
   assign code     = cmd_ff.data_word[qdac_pkg::DATA_W-1 -: CODE_BITS];
   assign rst_code = reset_code_ff[qdac_pkg::DATA_W-1 -: CODE_BITS];

   // Channel select, bits beyond the mask field or the channel count dropped
   always_comb begin
      sel = '0;
      for (int c = 0; c < SEL_W; c++) begin
         sel[c] = cmd_ff.channel_mask[c];
      end
   end

   always_comb begin
      last_bit = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         if ((IDX_W'(c) > idx_ff) && sel[c]) begin
            last_bit = 1'b0;
         end
      end
   end

   always_comb begin
      cmd_in = ctrl.load_cmd ? req_payload : cmd_ff;
   end

   always_comb begin
      dev_addr_in   = dev_addr_ff;
      reset_code_in = reset_code_ff;
      if (csr_we) begin
         case (csr_index)
            qdac_pkg::CSR_DEVICE_ADDRESS: dev_addr_in   = csr_wdata[qdac_pkg::ADDR_W-1:0];
            qdac_pkg::CSR_RESET_CODE:     reset_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Per-channel register updates, all lanes in the same cycle
   always_comb begin
      ldac_mask_in = ldac_mask_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         input_reg_in[c] = input_reg_ff[c];
         dac_reg_in[c]   = dac_reg_ff[c];
         power_in[c]     = power_ff[c];
      end
      if (ctrl.apply) begin
         case (op)
            qdac_pkg::OP_WRITE: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (sel[c]) input_reg_in[c] = code;
               end
            end
            qdac_pkg::OP_UPDATE: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (sel[c]) dac_reg_in[c] = input_reg_ff[c];
               end
            end
            qdac_pkg::OP_WRITE_UPDATE: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (sel[c]) begin
                     input_reg_in[c] = code;
                     dac_reg_in[c]   = code;
                  end
               end
            end
            qdac_pkg::OP_POWER: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  power_in[c] = cmd_ff.data_word[2*c +: qdac_pkg::PWR_W];
               end
            end
            qdac_pkg::OP_LDAC_MASK: begin
               ldac_mask_in = cmd_ff.data_word[CHANNELS-1:0];
            end
            qdac_pkg::OP_RESET: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  input_reg_in[c] = rst_code;
                  dac_reg_in[c]   = rst_code;
                  power_in[c]     = '0;
               end
               ldac_mask_in = '0;
            end
            qdac_pkg::OP_LDAC_PULSE: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (!ldac_mask_ff[c]) dac_reg_in[c] = input_reg_ff[c];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.clear_idx) begin
         idx_in = '0;
      end else if (ctrl.step_idx) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_in.read_data = (op == qdac_pkg::OP_READ_INPUT)
            ? qdac_pkg::DATA_W'(input_reg_ff[idx_ff]) << PAD_W
            : qdac_pkg::DATA_W'(dac_reg_ff[idx_ff]) << PAD_W;
         rsp_in.read_channel = qdac_pkg::RSP_CH_W'(idx_ff);
         rsp_in.power_mode   = power_ff[idx_ff];
         rsp_in.last         = last_bit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      if (reset) begin
         dev_addr_ff   <= '0;
         reset_code_ff <= '0;
         ldac_mask_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            input_reg_ff[c] <= '0;
            dac_reg_ff[c]   <= '0;
            power_ff[c]     <= '0;
         end
      end else begin
         dev_addr_ff   <= dev_addr_in;
         reset_code_ff <= reset_code_in;
         ldac_mask_ff  <= ldac_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            input_reg_ff[c] <= input_reg_in[c];
            dac_reg_ff[c]   <= dac_reg_in[c];
            power_ff[c]     <= power_in[c];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign stat.addr_match = (cmd_ff.target_address == dev_addr_ff);
   assign stat.is_read    = (op == qdac_pkg::OP_READ_INPUT) || (op == qdac_pkg::OP_READ_DAC);
   assign stat.sel_bit    = sel[idx_ff];
   assign stat.last_bit   = last_bit;
   assign stat.idx_at_end = (idx_ff == LastIdx);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/qdac_controller.sv
// Controller of the quad DAC command register file: accepts a command, decodes
// it, and sequences the readback channel scan. Uses qdac_pkg.
module qdac_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  qdac_pkg::stat_type stat,
   output qdac_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      emit_done;

   // Final selected channel handed over, or nothing left to look at
   assign emit_done = (stat.sel_bit && stat.rsp_free && stat.last_bit) ||
                      (!stat.sel_bit && stat.idx_at_end);

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      ctrl         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               ctrl.load_cmd = 1'b1;
               req_ready_in  = 1'b0;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.addr_match && stat.is_read) begin
               ctrl.clear_idx = 1'b1;
               state_in       = S_SCAN;
            end else begin
               ctrl.apply   = stat.addr_match;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            ctrl.load_rsp = stat.sel_bit && stat.rsp_free;
            ctrl.step_idx = !stat.sel_bit || (stat.rsp_free && !stat.last_bit);
            if (emit_done) begin
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            req_ready_in = 1'b1;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

FILE: rtl/quad_dac_command_register_file_unit.sv
// Top level of the quad DAC command register file.
// Instantiates qdac_controller and qdac_datapath; types come from qdac_pkg.
//
//   channel   ports                               moves per transfer
//   --------  ----------------------------------  -----------------------------
//   request   req_valid / req_ready / req_payload  one decoded command
//   response  rsp_valid / rsp_ready / rsp_payload  one readback result
//   csr       csr_we / csr_index / csr_wdata       one register write, no wait
//
// A command is transferred into the command register in S_IDLE and decoded in
// S_DECODE, where a non-readback command for this device is applied to the register
// file. A readback for this device then scans the channels one per cycle while the
// result register is free, channel 0 first; the scan counter in the datapath tracks
// the position. A result register separates the scan from the response side; the
// scan holds while that register is full and not being taken. Reset (synchronous,
// active high) clears the register file, CSRs and control state.
module quad_dac_command_register_file_unit #(
   parameter int CHANNELS  = qdac_pkg::CHANNELS_DEF,
   parameter int CODE_BITS = qdac_pkg::CODE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  qdac_pkg::req_type              req_payload,
   // Readback response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output qdac_pkg::rsp_type              rsp_payload,
   // Configuration write port
   input  logic                           csr_we,
   input  logic [qdac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qdac_pkg::DATA_W-1:0]    csr_wdata
);

   // Command and status between the control FSM and the datapath
   qdac_pkg::ctrl_type ctrl;
   qdac_pkg::stat_type stat;

   // Control: owns req_ready and the decode / scan sequencing
   qdac_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Datapath: register file, CSRs, scan counter and result register
   qdac_datapath #(
      .CHANNELS  (CHANNELS),
      .CODE_BITS (CODE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ctrl        (ctrl),
      .stat        (stat)
   );

endmodule

FILE: dv/quad_dac_command_register_file_unit_tb.sv
// Self-checking testbench for quad_dac_command_register_file_unit: directed and random
// command streams, with an in-bench predictor of the register file and readback results.
// Depends on qdac_pkg and the RTL of the unit only.
module quad_dac_command_register_file_unit_tb;

   localparam int CHANNELS  = qdac_pkg::CHANNELS_DEF;
   localparam int CODE_BITS = qdac_pkg::CODE_BITS_DEF;
   localparam int DATA_W    = qdac_pkg::DATA_W;
   localparam int ADDR_W    = qdac_pkg::ADDR_W;
   localparam int MASK_W    = qdac_pkg::MASK_W;
   localparam int OP_W      = qdac_pkg::OP_W;
   localparam int PWR_W     = qdac_pkg::PWR_W;

   // Codes are left-justified; the low bits below CODE_BITS are always zero.
   localparam logic [DATA_W-1:0] CODE_MASK = 16'hFFFF << (DATA_W - CODE_BITS);
   localparam logic [MASK_W-1:0] CHAN_BITS = MASK_W'((1 << CHANNELS) - 1);
   localparam int OP_CODE_MAX = (1 << OP_W) - 1;

   // A command passes through S_IDLE and S_DECODE and, for a readback, the channel scan;
   // pause before a CSR write so an unseen non-readback command has surely retired.
   localparam int SETTLE_CYCLES = 2 + CHANNELS + 6;

   // Longest legal stretch with no transfer: a sender gap, the command's own
   // processing, a receiver stall per result and the settle pause before CSR
   // writes. Take that several times over.
   localparam int STALL_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   qdac_pkg::req_type    req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   qdac_pkg::rsp_type    rsp_payload;
   logic                 csr_we;
   logic [qdac_pkg::CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   // Predicted device state and configuration
   logic [DATA_W-1:0] pred_input_reg [CHANNELS];
   logic [DATA_W-1:0] pred_dac_reg   [CHANNELS];
   logic [PWR_W-1:0]  pred_power     [CHANNELS];
   logic [MASK_W-1:0] pred_ldac_mask;
   logic [ADDR_W-1:0] pred_dev_addr;
   logic [DATA_W-1:0] pred_reset_code;

   // Readback results still owed by the unit, oldest first
   qdac_pkg::rsp_type pending_readbacks[$];

   int  fail_count = 0;
   int  quiet_cycles = 0;
   bit  traffic_idle_on = 1'b1;

   quad_dac_command_register_file_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: apply one accepted command to the predicted register file
   // and queue the readback results it causes.
   // ------------------------------------------------------------------
   task automatic apply_command(input qdac_pkg::req_type cmd);
      logic [MASK_W-1:0] sel;
      logic [DATA_W-1:0] code;
      qdac_pkg::rsp_type item;
      sel  = cmd.channel_mask & CHAN_BITS;
      code = cmd.data_word & CODE_MASK;
      // Drop commands aimed at another device
      if (cmd.target_address == pred_dev_addr) begin
         case (cmd.operation)
            qdac_pkg::OP_WRITE, qdac_pkg::OP_UPDATE, qdac_pkg::OP_WRITE_UPDATE: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (sel[c]) begin
                     if (cmd.operation != qdac_pkg::OP_UPDATE) pred_input_reg[c] = code;
                     if (cmd.operation != qdac_pkg::OP_WRITE)
                        pred_dac_reg[c] = pred_input_reg[c];
                  end
               end
            end
            qdac_pkg::OP_POWER: begin
               // Every channel takes its 2-bit field, selected or not
               for (int c = 0; c < CHANNELS; c++)
                  pred_power[c] = cmd.data_word[2*c +: PWR_W];
            end
            qdac_pkg::OP_LDAC_MASK: pred_ldac_mask = cmd.data_word[MASK_W-1:0] & CHAN_BITS;
            qdac_pkg::OP_RESET: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  pred_input_reg[c] = pred_reset_code & CODE_MASK;
                  pred_dac_reg[c]   = pred_reset_code & CODE_MASK;
                  pred_power[c]     = '0;
               end
               pred_ldac_mask = '0;
            end
            qdac_pkg::OP_LDAC_PULSE: begin
               // Masked channels hold their DAC value
               for (int c = 0; c < CHANNELS; c++)
                  if (!pred_ldac_mask[c]) pred_dac_reg[c] = pred_input_reg[c];
            end
            qdac_pkg::OP_READ_INPUT, qdac_pkg::OP_READ_DAC: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (sel[c]) begin
                     item.read_data    = (cmd.operation == qdac_pkg::OP_READ_INPUT) ?
                                         pred_input_reg[c] : pred_dac_reg[c];
                     item.read_channel = qdac_pkg::RSP_CH_W'(c);
                     item.power_mode   = pred_power[c];
                     item.last         = ((sel >> (c + 1)) == 0);
                     pending_readbacks.push_back(item);
                  end
               end
            end
            default: ; // nop and unused codes
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Present one command, hold it until the transfer, then predict it.
   task automatic send_command(input qdac_pkg::req_type cmd);
      int gap;
      gap = 0;
      if (traffic_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = cmd;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_command(cmd);
   endtask

   task automatic send_fields(input logic [ADDR_W-1:0] addr, input qdac_pkg::op_type op,
                              input logic [MASK_W-1:0] mask, input logic [DATA_W-1:0] data);
      qdac_pkg::req_type cmd;
      cmd.target_address = addr;
      cmd.operation      = op;
      cmd.channel_mask   = mask;
      cmd.data_word      = data;
      send_command(cmd);
   endtask

   // Drop valid, wait for every owed result, then let the unit go quiet.
   task automatic drain_readbacks();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readbacks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One-cycle CSR write; only called while the unit is idle.
   task automatic write_csr(input logic [qdac_pkg::CSR_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == qdac_pkg::CSR_DEVICE_ADDRESS) pred_dev_addr = value[ADDR_W-1:0];
      else if (idx == qdac_pkg::CSR_RESET_CODE) pred_reset_code = value;
   endtask

   function automatic qdac_pkg::req_type random_command();
      qdac_pkg::req_type cmd;
      int                pick;
      // Mostly commands for this device; the rest may or may not match
      cmd.target_address = ($urandom_range(0, 99) < 85) ? pred_dev_addr : ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12)      cmd.operation = qdac_pkg::OP_WRITE;
      else if (pick < 20) cmd.operation = qdac_pkg::OP_UPDATE;
      else if (pick < 32) cmd.operation = qdac_pkg::OP_WRITE_UPDATE;
      else if (pick < 38) cmd.operation = qdac_pkg::OP_POWER;
      else if (pick < 44) cmd.operation = qdac_pkg::OP_LDAC_MASK;
      else if (pick < 47) cmd.operation = qdac_pkg::OP_RESET;
      else if (pick < 55) cmd.operation = qdac_pkg::OP_LDAC_PULSE;
      else if (pick < 70) cmd.operation = qdac_pkg::OP_READ_INPUT;
      else if (pick < 87) cmd.operation = qdac_pkg::OP_READ_DAC;
      else if (pick < 91) cmd.operation = qdac_pkg::OP_NOP;
      else cmd.operation = OP_W'($urandom_range(int'(qdac_pkg::OP_READ_DAC) + 1, OP_CODE_MAX));
      cmd.channel_mask = MASK_W'($urandom);
      case ($urandom_range(0, 7))
         0:       cmd.data_word = '0;
         1:       cmd.data_word = '1;
         default: cmd.data_word = DATA_W'($urandom);
      endcase
      return cmd;
   endfunction

   // ------------------------------------------------------------------
   // Response side: random stall bursts on rsp_ready
   // ------------------------------------------------------------------
   always begin
      @(negedge clock);
      if (traffic_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      rsp_ready = 1'b1;
   end

   // Compare each transferred result with the oldest owed one
   always @(posedge clock) begin : check_readback
      qdac_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readbacks.size() == 0) begin
            $error("unexpected readback: read_data=%h read_channel=%0d power_mode=%0d last=%0b",
                   rsp_payload.read_data, rsp_payload.read_channel,
                   rsp_payload.power_mode, rsp_payload.last);
            fail_count++;
         end else begin
            want = pending_readbacks.pop_front();
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, rsp_payload.read_data);
               fail_count++;
            end
            if (rsp_payload.read_channel !== want.read_channel) begin
               $error("read_channel: expected %0d, actual %0d",
                      want.read_channel, rsp_payload.read_channel);
               fail_count++;
            end
            if (rsp_payload.power_mode !== want.power_mode) begin
               $error("power_mode: expected %0d, actual %0d",
                      want.power_mode, rsp_payload.power_mode);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Everything reads back as zero with normal power after reset
   task automatic test_reset_state();
      send_fields(2'd0, qdac_pkg::OP_READ_INPUT, 4'b1111, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,   4'b1111, 16'h0000);
   endtask

   // Write input only, update only, and write with update, at code extremes
   task automatic test_write_paths();
      send_fields(2'd0, qdac_pkg::OP_WRITE,        4'b0101, 16'hFFFF);
      send_fields(2'd0, qdac_pkg::OP_WRITE,        4'b1010, 16'h8001);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,     4'b1111, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_UPDATE,       4'b0001, 16'h5555);
      send_fields(2'd0, qdac_pkg::OP_WRITE_UPDATE, 4'b1000, 16'h7FFE);
      send_fields(2'd0, qdac_pkg::OP_READ_INPUT,   4'b1111, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,     4'b1111, 16'h0000);
   endtask

   // Power modes come from the low byte; the high byte must be ignored
   task automatic test_power_modes();
      send_fields(2'd0, qdac_pkg::OP_POWER,      4'b0000, 16'hFFE4);
      send_fields(2'd0, qdac_pkg::OP_READ_INPUT, 4'b1001, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_POWER,      4'b1111, 16'h001B);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,   4'b0110, 16'h0000);
   endtask

   // LDAC pulse updates only channels whose mask bit is clear
   task automatic test_ldac_pulse();
      send_fields(2'd0, qdac_pkg::OP_LDAC_MASK,  4'b0000, 16'hFFF5);
      send_fields(2'd0, qdac_pkg::OP_WRITE,      4'b1111, 16'h1234);
      send_fields(2'd0, qdac_pkg::OP_LDAC_PULSE, 4'b0000, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,   4'b1111, 16'h0000);
   endtask

   // Soft reset loads the reset code everywhere and clears modes and mask
   task automatic test_soft_reset();
      drain_readbacks();
      write_csr(qdac_pkg::CSR_RESET_CODE, 16'hFFFF);
      send_fields(2'd0, qdac_pkg::OP_RESET,      4'b0000, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_READ_INPUT, 4'b1111, 16'h0000);
      send_fields(2'd0, qdac_pkg::OP_READ_DAC,   4'b0010, 16'h0000);
   endtask

   // Foreign addresses, nop, unused code and empty readback give nothing; full read last
   task automatic test_address_filter();
      qdac_pkg::req_type cmd;
      drain_readbacks();
      write_csr(qdac_pkg::CSR_DEVICE_ADDRESS, 16'hFFFF);
      send_fields(2'd0, qdac_pkg::OP_WRITE,      4'b1111, 16'hAAAA);
      send_fields(2'd3, qdac_pkg::OP_NOP,        4'b1111, 16'h0F0F);
      cmd.target_address = 2'd3;
      cmd.operation      = OP_W'(OP_CODE_MAX);
      cmd.channel_mask   = 4'b1111;
      cmd.data_word      = 16'h0000;
      send_command(cmd);
      send_fields(2'd3, qdac_pkg::OP_READ_INPUT, 4'b0000, 16'h0000);
      send_fields(2'd1, qdac_pkg::OP_READ_INPUT, 4'b1111, 16'h0000);
      send_fields(2'd3, qdac_pkg::OP_READ_INPUT, 4'b1111, 16'h0000);
   endtask

   // Pause until idle, reconfigure, then stream random commands
   task automatic run_random_phase(input int count, input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] code);
      drain_readbacks();
      // Upper bits of the address write are don't-care; make them random
      write_csr(qdac_pkg::CSR_DEVICE_ADDRESS, {(DATA_W - ADDR_W)'($urandom), addr});
      write_csr(qdac_pkg::CSR_RESET_CODE, code);
      repeat (count) send_command(random_command());
   endtask

   task automatic test_random_traffic();
      run_random_phase(110, 2'd1, DATA_W'($urandom));
      run_random_phase(110, 2'd2, 16'h0000);
      run_random_phase(110, 2'd0, 16'hFFFF);
      // Close at full rate: no gaps, no stalls
      traffic_idle_on = 1'b0;
      run_random_phase(120, 2'd3, DATA_W'($urandom));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = qdac_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata   = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         pred_input_reg[c] = '0;
         pred_dac_reg[c]   = '0;
         pred_power[c]     = '0;
      end
      pred_ldac_mask  = '0;
      pred_dev_addr   = '0;
      pred_reset_code = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_write_paths();
      test_power_modes();
      test_ldac_pulse();
      test_soft_reset();
      test_address_filter();
      test_random_traffic();

      drain_readbacks();
      if (pending_readbacks.size() != 0) begin
         $error("%0d readback results never arrived", pending_readbacks.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
